// File: rtl/core/dq_pkg.sv
// Shared types, constants and index helpers for the double-ended queue.
package dq_pkg;

	localparam int CAPACITY = 1024;
	localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int SUM_W = ADDR_W + 1;
	localparam int DATA_W = 32;
	localparam int ENTRY_COUNT_W = 11;
	localparam int REQ_W = 3;
	localparam int IN_TDATA_W = 32;
	localparam int IN_TUSER_W = 3;
	localparam int OUT_TDATA_W = 112;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_FRONT = 3'd0,
		REQ_PUSH_BACK  = 3'd1,
		REQ_POP_FRONT  = 3'd2,
		REQ_POP_BACK   = 3'd3,
		REQ_QUERY      = 3'd4
	} req_type_t;

	typedef logic signed [DATA_W-1:0] value_t;

	// Result of one request as it leaves the state-update stage.
	typedef struct packed {
		value_t             popped_value;
		logic               pop_failed;
		logic               push_dropped;
		logic [CNT_W-1:0]   count;
		value_t             front_value;
		value_t             back_value;
		logic               front_from_ram;
		logic               back_from_ram;
	} res_t;

	// Fold a sum below twice the capacity back into the ring.
	function automatic logic [ADDR_W-1:0] wrap_idx(input logic [SUM_W-1:0] x);
		logic [SUM_W-1:0] r;
		r = (x >= SUM_W'(CAPACITY)) ? (x - SUM_W'(CAPACITY)) : x;
		return r[ADDR_W-1:0];
	endfunction

endpackage

// File: rtl/core/double_ended_queue_unit.sv
// Top level of the double-ended queue: input register, state update and result register.
// Path: a request passes the input register, then the state update with slot RAM access,
//   then the result register, in that order, before its result is offered.
// Throughput: one request per cycle while the result channel is not stalled; each
//   request makes at most one access to the single slot RAM, and the front and back
//   values are cached in registers.
// Reset: arst_n clears head index, entry count and all pipeline valids at once; the
//   slot RAM is not cleared, as only held entries are ever read.
module double_ended_queue_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	// Request channel
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [dq_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [31:0] push_value
	input  logic [dq_pkg::IN_TUSER_W-1:0]    s_axis_tuser,  // [2:0] req_type
	// Result channel
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [31:0] popped_value, [32] pop_failed, [33] push_dropped, [44:34] entry_count,
	// [45] is_empty, [77:46] front_value, [109:78] back_value, [111:110] zero
	output logic [dq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
	import dq_pkg::*;

	// The whole pipeline advances together whenever the result register can take
	// a new transfer; a stalled result holds every stage and the RAM read data.
	logic                adv;
	logic                v_s1;
	logic [REQ_W-1:0]    req_s1;
	value_t              val_s1;
	logic                v_s2;
	res_t                res_s2;
	value_t              rd_data;

	assign s_axis_tready = adv;

	// Input register: capture the request on each transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1 <= s_axis_tuser[REQ_W-1:0];
			val_s1 <= value_t'(s_axis_tdata[DATA_W-1:0]);
		end
	end

	// State update: move head/count, write or read one slot, cache the ends.
	dq_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.v_s1   (v_s1),
		.req_s1 (req_s1),
		.val_s1 (val_s1),
		.v_s2   (v_s2),
		.res_s2 (res_s2),
		.rd_data(rd_data)
	);

	// Result register: fold in the slot read and drive the result channel.
	dq_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.m_axis_tready(m_axis_tready),
		.v_s2         (v_s2),
		.res_s2       (res_s2),
		.rd_data      (rd_data),
		.adv          (adv),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tdata (m_axis_tdata)
	);

endmodule

// File: rtl/core/dq_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/dq_core.sv
// Ring-buffer state update: head/count registers, cached end values and slot RAM.
module dq_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       v_s1,
	input  logic [dq_pkg::REQ_W-1:0]   req_s1,
	input  dq_pkg::value_t             val_s1,
	output logic                       v_s2,
	output dq_pkg::res_t               res_s2,
	output dq_pkg::value_t             rd_data
);
	import dq_pkg::*;

	logic [ADDR_W-1:0] head_q;
	logic [CNT_W-1:0]  count_q;
	value_t            front_q;
	value_t            back_q;
	logic              front_rd_q;
	logic              back_rd_q;

	value_t            f;
	value_t            b;
	logic              full;
	logic              zero;
	logic [ADDR_W-1:0] head_dec;
	logic [ADDR_W-1:0] head_inc;
	logic [ADDR_W-1:0] tail_addr;
	logic [ADDR_W-1:0] last2_addr;

	logic [ADDR_W-1:0] head_n;
	logic [CNT_W-1:0]  count_n;
	value_t            front_n;
	value_t            back_n;
	logic              fpend;
	logic              bpend;
	logic              we_c;
	logic              re_c;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	value_t            popped;
	logic              pf;
	logic              pd;
	logic [DATA_W-1:0] rdata_raw;

	// A pending end value is the read that completed in the previous step.
	assign f = front_rd_q ? rd_data : front_q;
	assign b = back_rd_q ? rd_data : back_q;
	assign full = (count_q == CNT_W'(CAPACITY));
	assign zero = (count_q == '0);
	assign head_dec = (head_q == '0) ? ADDR_W'(CAPACITY - 1) : (head_q - 1'b1);
	assign head_inc = (head_q == ADDR_W'(CAPACITY - 1)) ? '0 : (head_q + 1'b1);
	assign tail_addr = wrap_idx(SUM_W'(head_q) + SUM_W'(count_q));
	assign last2_addr = wrap_idx(SUM_W'(head_q) + SUM_W'(count_q - CNT_W'(2)));

	always_comb begin
		head_n = head_q;
		count_n = count_q;
		front_n = f;
		back_n = b;
		fpend = 1'b0;
		bpend = 1'b0;
		we_c = 1'b0;
		re_c = 1'b0;
		waddr = tail_addr;
		raddr = head_inc;
		popped = '0;
		pf = 1'b0;
		pd = 1'b0;
		if (v_s1) begin
			case (req_type_t'(req_s1))
				REQ_PUSH_FRONT: begin
					if (full) begin
						pd = 1'b1;
					end else begin
						head_n = head_dec;
						count_n = count_q + 1'b1;
						we_c = 1'b1;
						waddr = head_dec;
						front_n = val_s1;
						if (zero) begin
							back_n = val_s1;
						end
					end
				end
				REQ_PUSH_BACK: begin
					if (full) begin
						pd = 1'b1;
					end else begin
						count_n = count_q + 1'b1;
						we_c = 1'b1;
						waddr = tail_addr;
						back_n = val_s1;
						if (zero) begin
							front_n = val_s1;
						end
					end
				end
				REQ_POP_FRONT: begin
					if (zero) begin
						popped = '1;
						pf = 1'b1;
					end else begin
						popped = f;
						head_n = head_inc;
						count_n = count_q - 1'b1;
						if (count_q != CNT_W'(1)) begin
							re_c = 1'b1;
							raddr = head_inc;
							fpend = 1'b1;
						end
					end
				end
				REQ_POP_BACK: begin
					if (zero) begin
						popped = '1;
						pf = 1'b1;
					end else begin
						popped = b;
						count_n = count_q - 1'b1;
						if (count_q != CNT_W'(1)) begin
							re_c = 1'b1;
							raddr = last2_addr;
							bpend = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	dq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we_c & adv),
		.waddr(waddr),
		.wdata(DATA_W'(val_s1)),
		.re   (re_c & adv),
		.raddr(raddr),
		.rdata(rdata_raw)
	);

	assign rd_data = value_t'(rdata_raw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			count_q <= '0;
			front_rd_q <= 1'b0;
			back_rd_q <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			head_q <= head_n;
			count_q <= count_n;
			front_rd_q <= fpend;
			back_rd_q <= bpend;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			front_q <= front_n;
			back_q <= back_n;
			res_s2.popped_value <= popped;
			res_s2.pop_failed <= pf;
			res_s2.push_dropped <= pd;
			res_s2.count <= count_n;
			res_s2.front_value <= front_n;
			res_s2.back_value <= back_n;
			res_s2.front_from_ram <= fpend;
			res_s2.back_from_ram <= bpend;
		end
	end

endmodule

// File: rtl/core/dq_out.sv
// Result register: resolve RAM-sourced end values and pack the output transfer.
module dq_out (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             m_axis_tready,
	input  logic                             v_s2,
	input  dq_pkg::res_t                     res_s2,
	input  dq_pkg::value_t                   rd_data,
	output logic                             adv,
	output logic                             m_axis_tvalid,
	output logic [dq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
	import dq_pkg::*;

	logic                     empty;
	value_t                   front_v;
	value_t                   back_v;
	logic [ENTRY_COUNT_W-1:0] entry;
	logic                     valid_q;
	logic [OUT_TDATA_W-1:0]   data_q;

	assign adv = !valid_q || m_axis_tready;
	assign empty = (res_s2.count == '0);
	assign entry = ENTRY_COUNT_W'(res_s2.count);
	assign front_v = empty ? value_t'('1)
		: (res_s2.front_from_ram ? rd_data : res_s2.front_value);
	assign back_v = empty ? value_t'('1)
		: (res_s2.back_from_ram ? rd_data : res_s2.back_value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_q <= {2'b00, back_v, front_v, empty, entry, res_s2.push_dropped,
				res_s2.pop_failed, res_s2.popped_value};
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata = data_q;

endmodule

// File: rtl/core/dq_checker.sv
// Port-level checks of the double-ended queue result channel, bound to the top level.
module dq_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [dq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
	import dq_pkg::*;

	// Hold a stalled result.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[45] == (m_axis_tdata[44:34] == '0)))
		else $error("is_empty disagrees with entry_count");

	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[45] |->
			(m_axis_tdata[77:46] == '1) && (m_axis_tdata[109:78] == '1))
		else $error("empty queue reports ends other than -1");

	a_pop_fail: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[32] |->
			(m_axis_tdata[31:0] == '1) && m_axis_tdata[45] && !m_axis_tdata[33])
		else $error("failed pop inconsistent");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[33] |->
			(m_axis_tdata[44:34] == ENTRY_COUNT_W'(CAPACITY)))
		else $error("dropped push without a full queue");

endmodule

bind double_ended_queue_unit dq_checker u_dq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);
